// ----- hw/rtl/serial_line_editor_echo_macros.svh -----
// assertion helpers shared by the line editor
`ifndef SERIAL_LINE_EDITOR_ECHO_MACROS_SVH
`define SERIAL_LINE_EDITOR_ECHO_MACROS_SVH

// checked only out of reset
`define SLE_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// checked on every edge, reset included
`define SLE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/sle_pkg.sv -----
package sle_pkg;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChDel = 8'h7F;
  localparam logic [7:0] ChSp  = 8'h20;

  typedef enum logic {
    MsgErase,
    MsgLong
  } msg_e;

  localparam logic [4:0] EraseLen = 5'd3;
  localparam logic [4:0] LongLen  = 5'd20;

  // "\r\nCommand too long\r\n", entry 0 first
  localparam logic [19:0][7:0] LongText = {
    8'h0A, 8'h0D, 8'h67, 8'h6E, 8'h6F, 8'h6C, 8'h20, 8'h6F, 8'h6F, 8'h74,
    8'h20, 8'h64, 8'h6E, 8'h61, 8'h6D, 8'h6D, 8'h6F, 8'h43, 8'h0A, 8'h0D
  };

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       line_last;
    logic       run_last;
  } res_t;

  function automatic logic [7:0] msg_byte(msg_e m, logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (m)
      MsgErase: b = (idx == 5'd1) ? ChSp : ChBs;
      MsgLong: begin
        if (idx < LongLen) begin
          b = LongText[idx];
        end
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] msg_len(msg_e m);
    logic [4:0] n;
    case (m)
      MsgErase: n = EraseLen;
      MsgLong:  n = LongLen;
      default:  n = EraseLen;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/sle_ifs.sv -----
interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       line_last;
  logic       run_last;

  modport source (output valid, output echo_valid, output echo_byte, output line_valid,
                  output line_byte, output line_last, output run_last, input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input line_valid,
                  input line_byte, input line_last, input run_last, output ready);
endinterface

// ----- hw/rtl/serial_line_editor_echo.sv -----
// order: an ordinary byte offers its echo in the cycle after its transfer; a message is
// sequenced in StMsg, and a command readout passes StPrime and StLine, before the output register
// throughput: one result per cycle while the output is taken; input is taken only when
// idle, so a new byte waits until every result of the last one has been offered; a
// command readout first primes the registered line store read in StPrime
// reset: asynchronous, clears the fill count and the output; the line store is not cleared
`include "serial_line_editor_echo_macros.svh"

module serial_line_editor_echo #(
  parameter int unsigned LINE_BYTES = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  sle_in_if.sink    in_i,
  sle_out_if.source out_o
);

  localparam int unsigned AW = $clog2(LINE_BYTES);

  // line store port, driven by the editor control
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // editor control: fill count, message sequencer, command readout and the output register
  sle_ctrl #(
    .LineBytes (LINE_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // character store, one write and one registered read a cycle; writes only happen
  // while idle, so they never meet a readout
  sle_line_mem #(
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // terms for the checks below
  logic out_free;
  logic last_shown;
  logic lane_idle;
  logic lane_clear;

  assign out_free   = !out_o.valid || out_o.ready;
  assign last_shown = out_o.valid && out_o.line_last;
  assign lane_idle  = out_o.valid && !out_o.line_valid;
  assign lane_clear = (out_o.line_byte == 8'h00) && !out_o.line_last;

  // a new byte is only taken when the result register can move on
  `SLE_ASSERT(a_in_needs_room, clk_i, rst_ni, in_i.ready |-> out_free, "input taken while blocked")
  // end of command flag only on a command character
  `SLE_ASSERT(a_last_on_char, clk_i, rst_ni, last_shown |-> out_o.line_valid, "stray line_last")
  // idle lanes carry zero
  `SLE_ASSERT(a_zero_lanes, clk_i, rst_ni, lane_idle |-> lane_clear, "idle command lane not zero")
  // nothing offered while in reset
  `SLE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_o.valid, "output valid during reset")

endmodule

// ----- hw/rtl/sle_line_mem.sv -----
module sle_line_mem #(
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [2**AddrW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sle_ctrl.sv -----
module sle_ctrl import sle_pkg::*; #(
  parameter int unsigned LineBytes = 64,
  localparam int unsigned AW = $clog2(LineBytes)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sle_in_if.sink        in_i,
  sle_out_if.source     out_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [7:0]    mem_rdata_i
);

  localparam logic [AW-1:0] CntMax = AW'(LineBytes - 1);

  typedef enum logic [1:0] {
    StIdle,
    StPrime,
    StLine,
    StMsg
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] k_q, k_d;
  logic [7:0]    cur_q, cur_d;
  logic          live_q, live_d;
  msg_e          msg_q, msg_d;
  logic [4:0]    idx_q, idx_d;
  res_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          can_emit, in_ready, fire_in;
  logic [7:0]    b;
  logic [AW-1:0] k1;
  logic          lv, lst, more, rl, ev;

  always_comb begin
    can_emit = !out_valid_q || out_o.ready;
    in_ready = (state_q == StIdle) && can_emit;
    fire_in  = in_i.valid && in_ready;
    b        = in_i.rx_byte;

    // command step: cur_q holds entry k, read data holds entry k+1
    k1   = k_q + AW'(1);
    lv   = live_q && (k_q < cnt_q) && (cur_q != 8'h00);
    lst  = lv && ((k1 == cnt_q) || (mem_rdata_i == 8'h00));
    more = lv && !lst;
    rl   = (k_q != '0) && !more;
    ev   = (k_q[AW-1:1] == '0);

    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    cur_d       = cur_q;
    live_d      = live_q;
    msg_d       = msg_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q;
    mem_wdata_o = b;
    mem_raddr_o = '0;

    case (state_q)
      StIdle: begin
        if (fire_in) begin
          if ((b == ChCr) || (b == ChLf)) begin
            fill_d = '0;
            if (fill_q != '0) begin
              cnt_d   = fill_q;
              k_d     = '0;
              live_d  = 1'b1;
              state_d = StPrime;
            end
          end else if ((b == ChBs) || (b == ChDel)) begin
            if (fill_q != '0) begin
              fill_d  = fill_q - AW'(1);
              msg_d   = MsgErase;
              idx_d   = '0;
              state_d = StMsg;
            end
          end else if (fill_q != CntMax) begin
            mem_we_o    = 1'b1;
            fill_d      = fill_q + AW'(1);
            out_valid_d = 1'b1;
            out_d       = '{echo_valid: 1'b1, echo_byte: b, line_valid: 1'b0,
                            line_byte: 8'h00, line_last: 1'b0, run_last: 1'b1};
          end else begin
            fill_d  = '0;
            msg_d   = MsgLong;
            idx_d   = '0;
            state_d = StMsg;
          end
        end
      end
      StPrime: begin
        cur_d       = mem_rdata_i;
        mem_raddr_o = k1;
        state_d     = StLine;
      end
      StLine: begin
        mem_raddr_o = can_emit ? (k_q + AW'(2)) : k1;
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '{echo_valid: ev,
                          echo_byte:  ev ? ((k_q == '0) ? ChCr : ChLf) : 8'h00,
                          line_valid: lv,
                          line_byte:  lv ? cur_q : 8'h00,
                          line_last:  lst,
                          run_last:   rl};
          cur_d  = mem_rdata_i;
          k_d    = k1;
          live_d = lv;
          if (rl) begin
            state_d = StIdle;
          end
        end
      end
      StMsg: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '{echo_valid: 1'b1, echo_byte: msg_byte(msg_q, idx_q),
                          line_valid: 1'b0, line_byte: 8'h00, line_last: 1'b0,
                          run_last: (idx_q == msg_len(msg_q) - 5'd1)};
          idx_d = idx_q + 5'd1;
          if (idx_q == msg_len(msg_q) - 5'd1) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      cur_q       <= '0;
      live_q      <= 1'b0;
      msg_q       <= MsgErase;
      idx_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      cur_q       <= cur_d;
      live_q      <= live_d;
      msg_q       <= msg_d;
      idx_q       <= idx_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.echo_valid = out_q.echo_valid;
  assign out_o.echo_byte  = out_q.echo_byte;
  assign out_o.line_valid = out_q.line_valid;
  assign out_o.line_byte  = out_q.line_byte;
  assign out_o.line_last  = out_q.line_last;
  assign out_o.run_last   = out_q.run_last;

endmodule
